>>> rtl/occ_pkg.sv
// Package for the order crossover engine.
// Holds field widths, queue depths and the structs passed between blocks.
// No dependencies.
package occ_pkg;

    localparam int GENE_W         = 6;
    localparam int NUM_GENES      = 2 ** GENE_W;
    localparam int POS_W          = 6;
    localparam int LEN_W          = 7;
    localparam int MAX_CITIES_DEF = 64;
    localparam int JOB_DEPTH_DEF  = 2;
    localparam int OUT_DEPTH_DEF  = 4;

    // parent store write request from the front
    typedef struct packed {
        logic              v;
        logic              bank;
        logic [POS_W-1:0]  pos;
        logic [GENE_W-1:0] g1;
        logic [GENE_W-1:0] g2;
    } t_wr;

    // one complete tour waiting for a build
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } t_job;

    // one child beat
    typedef struct packed {
        logic [GENE_W-1:0] gene;
        logic              last;
    } t_out;

endpackage

>>> rtl/order_crossover_engine.sv
// Top level of the order crossover engine.
// Joins occ_front, the job queue, occ_back and the child beat queue; uses occ_pkg.
//
//  channel | handshake          | beat
//  --------+--------------------+---------------------------------------------
//  pairs   | push / full        | i_first_gene i_second_gene i_cut_one
//          |                    | i_cut_two i_last_pair
//  child   | empty / pop        | o_child_gene o_last_child
//
// Pairs enter one per cycle while full is low. A tour of len positions then
// builds in the back part (clear, segment copy, scan of the second parent,
// emit), paced by the single read port of each parent bank and of the child
// store. Two parent banks let the next tour load while one builds; full rises
// with both held. Synchronous active-low reset empties both queues; a stalled
// empty/pop side holds the back part once the four-beat child queue fills.
module order_crossover_engine
    import occ_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int JOB_DEPTH  = JOB_DEPTH_DEF,
    parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [GENE_W-1:0] i_first_gene,
    input  logic [GENE_W-1:0] i_second_gene,
    input  logic [GENE_W-1:0] i_cut_one,
    input  logic [GENE_W-1:0] i_cut_two,
    input  logic              i_last_pair,
    output logic              empty,
    input  logic              pop,
    output logic [GENE_W-1:0] o_child_gene,
    output logic              o_last_child
);

    localparam int JW  = $bits(t_job);
    localparam int OW  = $bits(t_out);
    localparam int JCW = $clog2(JOB_DEPTH+1);
    localparam int OCW = $clog2(OUT_DEPTH+1);

    t_wr            wr;
    t_job           job_in;
    t_job           job_out;
    logic [JW-1:0]  job_q;
    logic           job_push;
    logic           job_full;
    logic           job_empty;
    logic           job_pop;
    logic           job_done;
    logic [JCW-1:0] job_cnt;
    t_out           out_in;
    t_out           out_q;
    logic [OW-1:0]  out_data;
    logic           out_push;
    logic           out_full;
    logic [OCW-1:0] out_cnt;

    occ_front #(
        .MAX_CITIES (MAX_CITIES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_first_gene  (i_first_gene),
        .i_second_gene (i_second_gene),
        .i_cut_one     (i_cut_one),
        .i_cut_two     (i_cut_two),
        .i_last_pair   (i_last_pair),
        .i_job_done    (job_done),
        .o_wr          (wr),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    occ_fifo #(
        .W     (JW),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_q),
        .o_empty (job_empty),
        .o_count (job_cnt)
    );

    assign job_out = t_job'(job_q);

    occ_back #(
        .MAX_CITIES (MAX_CITIES),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_job_done  (job_done),
        .i_out_count (out_cnt),
        .o_out_push  (out_push),
        .o_out       (out_in)
    );

    occ_fifo #(
        .W     (OW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_count (out_cnt)
    );

    assign out_q        = t_out'(out_data);
    assign o_child_gene = out_q.gene;
    assign o_last_child = out_q.last;

    a_job_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !job_full)
        else $error("job posted to a full queue");

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("child beat pushed to a full queue");

    a_job_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> (job_cnt != '0))
        else $error("job taken from an empty queue");

endmodule

>>> rtl/occ_fifo.sv
// Small register queue used for build jobs and for child beats.
// Depends on nothing but its parameters.
module occ_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [W-1:0]                 i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [W-1:0]                 o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH+1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PW-1:0]  r_rd;
    logic [PW-1:0]  r_wr;
    logic [CNW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CNW'(do_push) - CNW'(do_pop);
        end
    end

endmodule

>>> rtl/occ_front.sv
// Front of the crossover engine: accepts gene pairs, counts the tour,
// clamps and orders the cuts and posts a build job. Uses occ_pkg.
module occ_front
    import occ_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [GENE_W-1:0] i_first_gene,
    input  logic [GENE_W-1:0] i_second_gene,
    input  logic [GENE_W-1:0] i_cut_one,
    input  logic [GENE_W-1:0] i_cut_two,
    input  logic              i_last_pair,
    input  logic              i_job_done,
    output t_wr               o_wr,
    output logic              o_job_push,
    output t_job              o_job
);

    localparam int CW = $clog2(MAX_CITIES+1);
    localparam int XW = (CW > GENE_W) ? CW : GENE_W;
    localparam logic [1:0] NUM_BANKS = 2'd2;

    logic [CW-1:0] r_pair_cnt;
    logic          r_bank;
    logic [1:0]    r_busy;
    logic [1:0]    n_busy;

    logic          accept;
    logic          room;
    logic [CW-1:0] len_c;
    logic [XW-1:0] lim;
    logic [XW-1:0] c1;
    logic [XW-1:0] c2;
    logic [XW-1:0] lo;
    logic [XW-1:0] hi;

    assign o_full = (r_busy == NUM_BANKS);
    assign accept = i_push & ~o_full;
    assign room   = (r_pair_cnt != CW'(MAX_CITIES));

    always_comb begin
        len_c = room ? r_pair_cnt + CW'(1) : r_pair_cnt;
        lim   = XW'(len_c) - XW'(1);
        c1    = (XW'(i_cut_one) > lim) ? lim : XW'(i_cut_one);
        c2    = (XW'(i_cut_two) > lim) ? lim : XW'(i_cut_two);
        lo    = (c1 < c2) ? c1 : c2;
        hi    = (c1 < c2) ? c2 : c1;
    end

    always_comb begin
        o_wr.v    = accept & room;
        o_wr.bank = r_bank;
        o_wr.pos  = POS_W'(r_pair_cnt);
        o_wr.g1   = i_first_gene;
        o_wr.g2   = i_second_gene;
    end

    assign o_job_push = accept & i_last_pair;

    always_comb begin
        o_job.bank = r_bank;
        o_job.len  = LEN_W'(len_c);
        o_job.lo   = POS_W'(lo);
        o_job.hi   = POS_W'(hi);
    end

    assign n_busy = r_busy + {1'b0, o_job_push} - {1'b0, i_job_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_cnt <= '0;
            r_bank     <= 1'b0;
            r_busy     <= '0;
        end else begin
            r_busy <= n_busy;
            if (accept) begin
                if (i_last_pair) begin
                    r_pair_cnt <= '0;
                    r_bank     <= ~r_bank;
                end else if (room) begin
                    r_pair_cnt <= r_pair_cnt + CW'(1);
                end
            end
        end
    end

endmodule

>>> rtl/occ_back.sv
// Back of the crossover engine: holds both parent banks and the child store,
// copies the segment, fills from the second parent and streams the child.
// Uses occ_pkg.
module occ_back
    import occ_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_wr                            i_wr,
    input  logic                           i_job_empty,
    input  t_job                           i_job,
    output logic                           o_job_pop,
    output logic                           o_job_done,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_out_push,
    output t_out                           o_out
);

    localparam int AW   = $clog2(MAX_CITIES);
    localparam int MW   = $clog2(2*MAX_CITIES);
    localparam int OCW  = $clog2(OUT_DEPTH+1);
    localparam int OCW1 = OCW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_SEG, S_SCAN, S_WAIT, S_EMIT
    } t_state;

    logic [GENE_W-1:0] r_first_mem  [2*MAX_CITIES];
    logic [GENE_W-1:0] r_second_mem [2*MAX_CITIES];
    logic [GENE_W-1:0] r_child_mem  [MAX_CITIES];

    t_state               r_state;
    t_job                 r_job;
    logic [POS_W-1:0]     r_idx;
    logic [LEN_W-1:0]     r_fill;
    logic [NUM_GENES-1:0] r_used;
    logic [MAX_CITIES-1:0] r_vld;
    logic                 r_p_v;
    logic                 r_p_seg;
    logic [POS_W-1:0]     r_p_pos;
    logic [GENE_W-1:0]    r_rd1;
    logic [GENE_W-1:0]    r_rd2;
    logic [GENE_W-1:0]    r_child_q;
    logic                 r_e_v;
    logic                 r_e_vbit;
    logic                 r_e_last;
    logic                 r_done;

    logic [MW-1:0]     wr_idx;
    logic [MW-1:0]     rd_idx;
    logic [GENE_W-1:0] g;
    logic [LEN_W-1:0]  len_m1;
    logic [LEN_W-1:0]  hi1;
    logic [LEN_W-1:0]  skip;
    logic [LEN_W-1:0]  fill_s;
    logic [LEN_W-1:0]  fill_inc;
    logic [LEN_W-1:0]  fill_nx;
    logic              is_new;
    logic              cw_v;
    logic [POS_W-1:0]  cw_pos;
    logic              room;
    logic              idx_at_end;

    always_comb begin
        wr_idx = MW'(i_wr.pos) + (i_wr.bank ? MW'(MAX_CITIES) : MW'(0));
        rd_idx = MW'(r_idx) + (r_job.bank ? MW'(MAX_CITIES) : MW'(0));
    end

    // parent banks
    always_ff @(posedge i_clk) begin
        if (i_wr.v) begin
            r_first_mem[wr_idx]  <= i_wr.g1;
            r_second_mem[wr_idx] <= i_wr.g2;
        end
        r_rd1 <= r_first_mem[rd_idx];
        r_rd2 <= r_second_mem[rd_idx];
    end

    // placement of one gene
    always_comb begin
        g        = r_p_seg ? r_rd1 : r_rd2;
        len_m1   = r_job.len - LEN_W'(1);
        hi1      = LEN_W'(r_job.hi) + LEN_W'(1);
        skip     = (hi1 >= r_job.len) ? '0 : hi1;
        fill_s   = (r_fill == LEN_W'(r_job.lo)) ? skip : r_fill;
        fill_inc = fill_s + LEN_W'(1);
        fill_nx  = (fill_inc >= r_job.len) ? '0 : fill_inc;
        is_new   = ~r_used[g];
        cw_v     = r_p_v & (r_p_seg | is_new);
        cw_pos   = r_p_seg ? r_p_pos : POS_W'(fill_s);
        room     = ({1'b0, i_out_count} + OCW1'(r_e_v)) < OCW1'(OUT_DEPTH);
        idx_at_end = (LEN_W'(r_idx) == len_m1);
    end

    // child store
    always_ff @(posedge i_clk) begin
        if (cw_v) begin
            r_child_mem[cw_pos[AW-1:0]] <= g;
        end
        r_child_q <= r_child_mem[r_idx[AW-1:0]];
    end

    assign o_job_pop  = (r_state == S_IDLE) & ~i_job_empty;
    assign o_job_done = r_done;
    assign o_out_push = r_e_v;

    always_comb begin
        o_out.gene = r_e_vbit ? r_child_q : '0;
        o_out.last = r_e_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_fill   <= '0;
            r_used   <= '0;
            r_vld    <= '0;
            r_p_v    <= 1'b0;
            r_p_seg  <= 1'b0;
            r_e_v    <= 1'b0;
            r_e_last <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_p_v  <= 1'b0;
            r_e_v  <= 1'b0;
            r_done <= 1'b0;

            if (r_p_v) begin
                if (r_p_seg || is_new) begin
                    r_used[g]                <= 1'b1;
                    r_vld[cw_pos[AW-1:0]]    <= 1'b1;
                end
                if (!r_p_seg) begin
                    r_fill <= is_new ? fill_nx : fill_s;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job   <= i_job;
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    r_used  <= '0;
                    r_vld   <= '0;
                    r_fill  <= '0;
                    r_idx   <= r_job.lo;
                    r_state <= S_SEG;
                end
                S_SEG: begin
                    r_p_v   <= 1'b1;
                    r_p_seg <= 1'b1;
                    r_p_pos <= r_idx;
                    if (r_idx == r_job.hi) begin
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_idx <= r_idx + POS_W'(1);
                    end
                end
                S_SCAN: begin
                    r_p_v   <= 1'b1;
                    r_p_seg <= 1'b0;
                    r_p_pos <= r_idx;
                    if (idx_at_end) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_idx <= r_idx + POS_W'(1);
                    end
                end
                S_WAIT: begin
                    r_idx   <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (room) begin
                        r_e_v    <= 1'b1;
                        r_e_vbit <= r_vld[r_idx[AW-1:0]];
                        r_e_last <= idx_at_end;
                        if (idx_at_end) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + POS_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sim/tb_order_crossover_engine.sv
// Self-checking testbench for order_crossover_engine: parent tours in, child tours out.
// Compares every child beat against a built-in crossover predictor; uses occ_pkg.
`timescale 1ns / 100ps

module tb_order_crossover_engine;
    import occ_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 140;
    localparam int TAIL_CYCLES = 300;

    typedef enum int {
        TOUR_PERM,
        TOUR_NOISE,
        TOUR_MIXED,
        TOUR_FLAT
    } t_tour_kind;

    typedef struct packed {
        logic [GENE_W-1:0] g1;
        logic [GENE_W-1:0] g2;
        logic [GENE_W-1:0] c1;
        logic [GENE_W-1:0] c2;
        logic              last;
    } t_pair;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_push        = 1'b0;
    logic [GENE_W-1:0] i_first_gene  = '0;
    logic [GENE_W-1:0] i_second_gene = '0;
    logic [GENE_W-1:0] i_cut_one     = '0;
    logic [GENE_W-1:0] i_cut_two     = '0;
    logic              i_last_pair   = 1'b0;
    logic              i_pop         = 1'b0;
    logic              o_full;
    logic              o_empty;
    logic [GENE_W-1:0] o_child_gene;
    logic              o_last_child;

    t_pair             pairs_todo[$];
    t_out              child_beats_due[$];
    logic [GENE_W-1:0] parent_a [NUM_GENES];
    logic [GENE_W-1:0] parent_b [NUM_GENES];
    int                pairs_held  = 0;
    int                sent_beats  = 0;
    int                child_seen  = 0;
    int                item_total  = 0;
    int                error_count = 0;
    int                cycle_count = 0;

    order_crossover_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (i_push),
        .full          (o_full),
        .i_first_gene  (i_first_gene),
        .i_second_gene (i_second_gene),
        .i_cut_one     (i_cut_one),
        .i_cut_two     (i_cut_two),
        .i_last_pair   (i_last_pair),
        .empty         (o_empty),
        .pop           (i_pop),
        .o_child_gene  (o_child_gene),
        .o_last_child  (o_last_child)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("MISMATCH child beat %0d %s: got %0d expected %0d",
                 child_seen, what, got, want);
        error_count++;
    endtask

    // store one pair; on the last pair build the child and queue its beats
    task automatic cross_tour(input t_pair p);
        logic [GENE_W-1:0] child [NUM_GENES];
        bit                taken [NUM_GENES];
        logic [GENE_W-1:0] g;
        t_out              beat;
        int                len, a, b, lo, hi, fp, k;
        if (pairs_held < MAX_CITIES_DEF) begin
            parent_a[pairs_held] = p.g1;
            parent_b[pairs_held] = p.g2;
            pairs_held++;
        end
        if (!p.last) return;
        len = pairs_held;
        a   = (int'(p.c1) > len - 1) ? len - 1 : int'(p.c1);
        b   = (int'(p.c2) > len - 1) ? len - 1 : int'(p.c2);
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        for (k = 0; k < NUM_GENES; k++) begin
            child[k] = '0;
            taken[k] = 1'b0;
        end
        for (k = lo; k <= hi; k++) begin
            child[k] = parent_a[k];
            taken[parent_a[k]] = 1'b1;
        end
        fp = 0;
        for (k = 0; k < len; k++) begin
            g = parent_b[k];
            if (fp == lo) fp = (hi + 1 >= len) ? 0 : hi + 1;
            if (!taken[g]) begin
                taken[g]  = 1'b1;
                child[fp] = g;
                fp++;
                if (fp >= len) fp = 0;
            end
        end
        for (k = 0; k < len; k++) begin
            beat.gene = child[k];
            beat.last = (k == len - 1);
            child_beats_due = {child_beats_due, beat};
        end
        pairs_held = 0;
    endtask

    task automatic add_tour(input int n, input t_tour_kind kind, input int c1, input int c2);
        int    deck  [NUM_GENES];
        int    deck2 [NUM_GENES];
        int    k, j, t, m;
        t_pair p;
        m = (n < NUM_GENES) ? n : NUM_GENES;
        for (k = 0; k < NUM_GENES; k++) deck[k] = k;
        for (k = NUM_GENES - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = deck[k]; deck[k] = deck[j]; deck[j] = t;
        end
        for (k = 0; k < m; k++) deck2[k] = deck[k];
        for (k = m - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = deck2[k]; deck2[k] = deck2[j]; deck2[j] = t;
        end
        for (k = 0; k < n; k++) begin
            p.last = (k == n - 1);
            p.c1   = p.last ? c1[GENE_W-1:0] : GENE_W'($urandom_range(0, NUM_GENES - 1));
            p.c2   = p.last ? c2[GENE_W-1:0] : GENE_W'($urandom_range(0, NUM_GENES - 1));
            p.g1   = GENE_W'($urandom_range(0, NUM_GENES - 1));
            p.g2   = GENE_W'($urandom_range(0, NUM_GENES - 1));
            if (k < NUM_GENES) begin
                case (kind)
                    TOUR_PERM: begin
                        p.g1 = GENE_W'(deck[k]);
                        p.g2 = GENE_W'(deck2[k]);
                    end
                    TOUR_MIXED: p.g1 = GENE_W'(deck[k]);
                    TOUR_FLAT: begin
                        p.g1 = '1;
                        p.g2 = '0;
                    end
                    default: ;
                endcase
            end
            pairs_todo = {pairs_todo, p};
        end
    endtask

    function automatic int load_phase();
        int p;
        if (item_total == 0) return 2;
        p = sent_beats * 3 / item_total;
        return (p > 2) ? 2 : p;
    endfunction

    function automatic int send_idle_pct();
        case (load_phase())
            0:       return 15;
            1:       return 53;
            default: return 0;
        endcase
    endfunction

    function automatic int take_idle_pct();
        case (load_phase())
            0:       return 53;
            1:       return 15;
            default: return 0;
        endcase
    endfunction

    // pair driver
    always @(posedge i_clk) begin
        t_pair nxt;
        t_pair cur;
        bit    advance;
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            advance = !i_push;
            if (i_push && !o_full) begin
                cur = '{i_first_gene, i_second_gene, i_cut_one, i_cut_two, i_last_pair};
                cross_tour(cur);
                sent_beats++;
                advance = 1'b1;
            end
            if (advance) begin
                if (pairs_todo.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    nxt = pairs_todo.pop_front();
                    i_push        <= 1'b1;
                    i_first_gene  <= nxt.g1;
                    i_second_gene <= nxt.g2;
                    i_cut_one     <= nxt.c1;
                    i_cut_two     <= nxt.c2;
                    i_last_pair   <= nxt.last;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // child beat monitor
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (child_beats_due.size() == 0) begin
                    note_mismatch("unexpected beat, gene", o_child_gene, 0);
                end else begin
                    want = child_beats_due.pop_front();
                    if (o_child_gene !== want.gene)
                        note_mismatch("child_gene", o_child_gene, want.gene);
                    if (o_last_child !== want.last)
                        note_mismatch("last_child", o_last_child, want.last);
                end
                child_seen++;
            end
            i_pop <= ($urandom_range(0, 99) >= take_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int         rand_items;
        int         n, r, top;
        bit         big_done;
        t_tour_kind kind;
        rand_items = 0;
        big_done   = 1'b0;

        add_tour(1, TOUR_PERM, 0, 0);
        add_tour(2, TOUR_PERM, 63, 0);
        add_tour(3, TOUR_PERM, 63, 63);
        add_tour(4, TOUR_PERM, 1, 3);
        add_tour(5, TOUR_FLAT, 1, 2);
        add_tour(6, TOUR_PERM, 4, 0);

        while (rand_items < RAND_ITEMS) begin
            if (!big_done && rand_items >= 60) begin
                n        = MAX_CITIES_DEF + $urandom_range(0, 3);
                big_done = 1'b1;
            end else begin
                n = $urandom_range(1, 10);
            end
            r = $urandom_range(0, 9);
            if (r < 6)      kind = TOUR_PERM;
            else if (r < 8) kind = TOUR_NOISE;
            else if (r < 9) kind = TOUR_MIXED;
            else            kind = TOUR_FLAT;
            top = (n > NUM_GENES) ? NUM_GENES - 1 : n - 1;
            if ($urandom_range(0, 1))
                add_tour(n, kind, $urandom_range(0, 63), $urandom_range(0, 63));
            else
                add_tour(n, kind, $urandom_range(0, top), $urandom_range(0, top));
            rand_items += n;
        end
        item_total = pairs_todo.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pairs_todo.size() > 0 || i_push || child_beats_due.size() > 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (child_beats_due.size() > 0)
            note_mismatch("missing beats, count", 0, child_beats_due.size());
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> order_crossover_engine.f
rtl/occ_pkg.sv
rtl/occ_fifo.sv
rtl/occ_front.sv
rtl/occ_back.sv
rtl/order_crossover_engine.sv
sim/tb_order_crossover_engine.sv
